### src/sp4x4_pkg.sv
// sp4x4_pkg: types, codes and constants shared by the spline interpolation unit
// used by sp4x4_front, sp4x4_back and the top level
`default_nettype none

package sp4x4_pkg;

  // default sizing of the top level
  localparam int COEF_DEPTH_DEF    = 65536;
  localparam int MAX_ROW_WIDTH_DEF = 256;
  localparam int TAPS_DEF          = 4;

  // fixed field widths
  localparam int IDX_W   = 8;
  localparam int WGT_W   = 16;
  localparam int COEF_W  = 24;
  localparam int CADDR_W = 16;
  localparam int RW_W    = 9;
  // row index times row width plus column index
  localparam int ADDR_FULL_W = 18;
  // weight product is Q2.30
  localparam int WPROD_W = 2 * WGT_W;
  localparam int PROD_W  = COEF_W + WPROD_W;
  localparam int FRAC_W  = 30;

  localparam int VAL_MAX = 8388607;
  localparam int VAL_MIN = -8388608;

  // command queue between front and back
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_WR_COEF = 2'd0,
    OP_SET_TAP = 2'd1,
    OP_EVAL    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_COEF,
    CMD_TAP,
    CMD_EVAL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } bk_state_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [1:0]                tap;
    logic [IDX_W-1:0]          x_index;
    logic signed [WGT_W-1:0]   x_weight;
    logic [IDX_W-1:0]          y_index;
    logic signed [WGT_W-1:0]   y_weight;
    logic [CADDR_W-1:0]        coef_addr;
    logic signed [COEF_W-1:0]  coef_data;
  } in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] interp_value;
    status_t                  status;
  } out_t;

  // one classified item waiting for the engine
  typedef struct packed {
    cmd_kind_t kind;
    in_t       item;
  } cmd_t;

endpackage : sp4x4_pkg

`default_nettype wire

### src/sp4x4_front.sv
// sp4x4_front: accepts input beats, drops those with no effect, queues the rest
// depends on sp4x4_pkg
`default_nettype none

module sp4x4_front #(
  parameter int COEF_DEPTH = sp4x4_pkg::COEF_DEPTH_DEF,
  parameter int TAPS       = sp4x4_pkg::TAPS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire sp4x4_pkg::in_t  in_data,
  output logic                 head_vld,
  output sp4x4_pkg::cmd_t      head,
  input  wire logic            pop
);
  import sp4x4_pkg::*;

  localparam int QW = $clog2(Q_DEPTH);

  cmd_t          q_r [Q_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QW:0]   count_r, count_nxt;
  logic          keep_c;
  cmd_kind_t     kind_c;
  logic          push;

  // classify: coefficient writes out of the store, bad taps and the unused
  // opcode leave no trace and are dropped here
  always_comb begin
    keep_c = 1'b0;
    kind_c = CMD_EVAL;
    case (opcode_t'(in_data.opcode))
      OP_WR_COEF: begin
        kind_c = CMD_COEF;
        keep_c = (32'(in_data.coef_addr) < COEF_DEPTH);
      end
      OP_SET_TAP: begin
        kind_c = CMD_TAP;
        keep_c = (32'(in_data.tap) < TAPS);
      end
      OP_EVAL: begin
        kind_c = CMD_EVAL;
        keep_c = 1'b1;
      end
      default: begin
        keep_c = 1'b0;
      end
    endcase
  end

  assign busy     = (count_r == (QW+1)'(Q_DEPTH));
  assign push     = start && !busy && keep_c;
  assign head_vld = (count_r != '0);
  assign head     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{kind: kind_c, item: in_data};
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("queue popped while empty");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_push_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queued beat lost");
`endif

endmodule : sp4x4_front

`default_nettype wire

### src/sp4x4_back.sv
// sp4x4_back: coefficient store, tap registers and the multiply-accumulate engine
// depends on sp4x4_pkg; takes classified commands from sp4x4_front
`default_nettype none

module sp4x4_back #(
  parameter int COEF_DEPTH    = sp4x4_pkg::COEF_DEPTH_DEF,
  parameter int MAX_ROW_WIDTH = sp4x4_pkg::MAX_ROW_WIDTH_DEF,
  parameter int TAPS          = sp4x4_pkg::TAPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sp4x4_pkg::RW_W-1:0]     cfg_wdata,
  input  wire logic                           head_vld,
  input  wire sp4x4_pkg::cmd_t                head,
  output logic                                pop,
  output logic                                out_strobe,
  output sp4x4_pkg::out_t                     out_data
);
  import sp4x4_pkg::*;

  localparam int AW     = $clog2(COEF_DEPTH);
  localparam int KW     = $clog2(TAPS);
  localparam int ACC_W  = PROD_W + 2 * KW;
  localparam int RW_RST = (MAX_ROW_WIDTH < 256) ? MAX_ROW_WIDTH : 256;
  localparam logic signed [ACC_W-1:0] RBIAS = ACC_W'(64'd1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] QMAX  = ACC_W'(VAL_MAX);
  localparam logic signed [ACC_W-1:0] QMIN  = ACC_W'(VAL_MIN);

  bk_state_t state_r, state_nxt;

  // row width register
  logic [RW_W-1:0] rw_r, rw_nxt;

  always_comb begin
    rw_nxt = rw_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        rw_nxt = RW_W'(1);
      end else if (32'(cfg_wdata) > MAX_ROW_WIDTH) begin
        rw_nxt = RW_W'(MAX_ROW_WIDTH);
      end else begin
        rw_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rw_r <= RW_W'(RW_RST);
    end else begin
      rw_r <= rw_nxt;
    end
  end

  // taps
  logic [IDX_W-1:0]        col_idx_r [TAPS];
  logic signed [WGT_W-1:0] col_wgt_r [TAPS];
  logic [IDX_W-1:0]        row_idx_r [TAPS];
  logic signed [WGT_W-1:0] row_wgt_r [TAPS];

  logic mem_we, tap_we, issue, acc_clr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        col_idx_r[i] <= '0;
        col_wgt_r[i] <= '0;
        row_idx_r[i] <= '0;
        row_wgt_r[i] <= '0;
      end
    end else if (tap_we) begin
      col_idx_r[KW'(head.item.tap)] <= head.item.x_index;
      col_wgt_r[KW'(head.item.tap)] <= head.item.x_weight;
      row_idx_r[KW'(head.item.tap)] <= head.item.y_index;
      row_wgt_r[KW'(head.item.tap)] <= head.item.y_weight;
    end
  end

  // term counters: k walks rows, j walks columns
  logic [KW-1:0] k_r, k_nxt, j_r, j_nxt;
  logic          last_c;

  assign last_c = (k_r == KW'(TAPS - 1)) && (j_r == KW'(TAPS - 1));

  always_comb begin
    k_nxt = k_r;
    j_nxt = j_r;
    if (acc_clr) begin
      k_nxt = '0;
      j_nxt = '0;
    end else if (issue) begin
      if (last_c) begin
        k_nxt = '0;
        j_nxt = '0;
      end else if (j_r == KW'(TAPS - 1)) begin
        j_nxt = '0;
        k_nxt = k_r + 1'b1;
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      j_r <= '0;
    end else begin
      k_r <= k_nxt;
      j_r <= j_nxt;
    end
  end

  // term address, range check and weight product
  logic [ADDR_FULL_W-1:0]    addr_c;
  logic                      bad_c;
  logic signed [WPROD_W-1:0] wprod_c;

  always_comb begin
    addr_c  = ADDR_FULL_W'(row_idx_r[k_r]) * ADDR_FULL_W'(rw_r)
            + ADDR_FULL_W'(col_idx_r[j_r]);
    bad_c   = ({1'b0, col_idx_r[j_r]} >= rw_r) || (32'(addr_c) >= COEF_DEPTH);
    wprod_c = row_wgt_r[k_r] * col_wgt_r[j_r];
  end

  // stage 1: address registered
  logic                      p1_vld_r, p1_last_r, p1_bad_r;
  logic [AW-1:0]             p1_addr_r;
  logic signed [WPROD_W-1:0] p1_wprod_r;
  // stage 2: store read data
  logic                      p2_vld_r, p2_last_r, p2_bad_r;
  logic signed [WPROD_W-1:0] p2_wprod_r;
  logic signed [COEF_W-1:0]  rd_data_r;
  logic signed [PROD_W-1:0]  prod_c;
  // stage 3: full product
  logic                      p3_vld_r, p3_last_r, p3_bad_r;
  logic signed [PROD_W-1:0]  p3_prod_r;
  // accumulator
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      bad_r, bad_nxt;
  logic                      fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r  <= 1'b0;
      p1_last_r <= 1'b0;
      p2_vld_r  <= 1'b0;
      p2_last_r <= 1'b0;
      p3_vld_r  <= 1'b0;
      p3_last_r <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      p1_vld_r  <= issue;
      p1_last_r <= issue && last_c;
      p2_vld_r  <= p1_vld_r;
      p2_last_r <= p1_last_r;
      p3_vld_r  <= p2_vld_r;
      p3_last_r <= p2_last_r;
      fin_r     <= p3_vld_r && p3_last_r;
    end
  end

  // signed product at full width
  always_comb begin
    prod_c = rd_data_r * p2_wprod_r;
  end

  always_ff @(posedge clk) begin
    p1_addr_r  <= AW'(addr_c);
    p1_bad_r   <= bad_c;
    p1_wprod_r <= wprod_c;
    p2_bad_r   <= p1_bad_r;
    p2_wprod_r <= p1_wprod_r;
    p3_bad_r   <= p2_bad_r;
    p3_prod_r  <= p2_bad_r ? '0 : prod_c;
  end

  // coefficient store, single port
  logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
  logic [AW-1:0]            mem_addr;

  assign mem_addr = mem_we ? AW'(head.item.coef_addr) : p1_addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      coef_mem[mem_addr] <= head.item.coef_data;
    end
    rd_data_r <= coef_mem[mem_addr];
  end

  always_comb begin
    acc_nxt = acc_r;
    bad_nxt = bad_r;
    if (acc_clr) begin
      acc_nxt = '0;
      bad_nxt = 1'b0;
    end else if (p3_vld_r) begin
      acc_nxt = acc_r + ACC_W'(p3_prod_r);
      bad_nxt = bad_r | p3_bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      bad_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      bad_r <= bad_nxt;
    end
  end

  // round half up, shift out the Q2.30 fraction, clamp to 24 bits
  logic signed [ACC_W-1:0] q_c;
  out_t                    res_c;

  always_comb begin
    q_c = (acc_r + RBIAS) >>> FRAC_W;
    res_c.status = ST_OK;
    if (q_c > QMAX) begin
      res_c.interp_value = COEF_W'(VAL_MAX);
      res_c.status       = ST_SAT;
    end else if (q_c < QMIN) begin
      res_c.interp_value = COEF_W'(VAL_MIN);
      res_c.status       = ST_SAT;
    end else begin
      res_c.interp_value = q_c[COEF_W-1:0];
    end
    if (bad_r) begin
      res_c.status = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_r) begin
      out_data <= res_c;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head_vld && (head.kind == CMD_EVAL)) begin
          state_nxt = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        if (last_c) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (fin_r) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    mem_we  = 1'b0;
    tap_we  = 1'b0;
    acc_clr = 1'b0;
    issue   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop = head_vld;
        if (head_vld) begin
          case (head.kind)
            CMD_COEF: mem_we  = 1'b1;
            CMD_TAP:  tap_we  = 1'b1;
            CMD_EVAL: acc_clr = 1'b1;
            default:  pop     = 1'b1;
          endcase
        end
      end
      BK_ISSUE: begin
        issue = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_write_during_read : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !p1_vld_r && !p2_vld_r && !p3_vld_r)
    else $error("store written while an evaluation is in flight");

  a_result_after_drain : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == BK_DRAIN))
    else $error("result strobe outside an evaluation");

  a_no_pop_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> !pop)
    else $error("command taken while the engine is busy");

  a_counters_home : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DRAIN) |-> (k_r == '0) && (j_r == '0))
    else $error("term counters did not wrap at the end of an evaluation");
`endif

endmodule : sp4x4_back

`default_nettype wire

### src/separable_4x4_spline_interpolation_unit.sv
// separable_4x4_spline_interpolation_unit: top level of the spline interpolator
// depends on sp4x4_pkg, sp4x4_front and sp4x4_back
`default_nettype none

// A beat is taken when start is high and busy is low; a two-entry command queue
// sits in front of the engine, so busy rises only when both entries are waiting.
// Coefficient writes and tap writes are taken straight from the queue while the engine is idle. An
// evaluation walks all TAPS*TAPS terms of the kernel: one
// coefficient read from the single-port store and one multiply-accumulate per
// term, then a drain through the read, product, accumulate and round
// stages. Its result appears on out_data with out_strobe high for exactly one
// cycle; there is no back-pressure, so the receiver must take it in that cycle.
// Write row width only while no evaluation is queued or running.

module separable_4x4_spline_interpolation_unit #(
  parameter int COEF_DEPTH    = sp4x4_pkg::COEF_DEPTH_DEF,
  parameter int MAX_ROW_WIDTH = sp4x4_pkg::MAX_ROW_WIDTH_DEF,
  parameter int TAPS          = sp4x4_pkg::TAPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire sp4x4_pkg::in_t              in_data,
  output logic                             out_strobe,
  output sp4x4_pkg::out_t                  out_data,
  input  wire logic                        cfg_we,
  input  wire logic [sp4x4_pkg::RW_W-1:0]  cfg_wdata
);
  import sp4x4_pkg::*;

  logic head_vld;
  cmd_t head;
  logic pop;

  sp4x4_front #(
    .COEF_DEPTH (COEF_DEPTH),
    .TAPS       (TAPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .head_vld (head_vld),
    .head     (head),
    .pop      (pop)
  );

  sp4x4_back #(
    .COEF_DEPTH    (COEF_DEPTH),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .TAPS          (TAPS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_vld   (head_vld),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule : separable_4x4_spline_interpolation_unit

`default_nettype wire

### tb/separable_4x4_spline_interpolation_unit_tb.sv
`timescale 1ns / 1ps
// separable_4x4_spline_interpolation_unit_tb: self-checking bench for the spline interpolator
// directed table, then random tap/coefficient/evaluate sequences over several row widths
// depends on sp4x4_pkg and separable_4x4_spline_interpolation_unit

module separable_4x4_spline_interpolation_unit_tb;
  import sp4x4_pkg::*;

  localparam int ITEM_TARGET = 1950;
  // longer than one evaluation plus the two queued commands
  localparam int SETTLE      = TAPS_DEF * TAPS_DEF + 12;

  localparam logic signed [WGT_W-1:0]  W_NEG1 = 16'sh8000;
  localparam logic signed [WGT_W-1:0]  W_MAX  = 16'sh7FFF;
  localparam logic signed [COEF_W-1:0] C_MAX  = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] C_MIN  = 24'sh800000;

  typedef struct {
    bit              is_cfg;
    logic [RW_W-1:0] cfg_val;
    in_t             beat;
    bit              typed;
    out_t            want;
  } stim_row_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  in_t             in_data   = '0;
  logic            out_strobe;
  out_t            out_data;
  logic            cfg_we    = 1'b0;
  logic [RW_W-1:0] cfg_wdata = '0;

  // predictor state
  logic signed [COEF_W-1:0] coef_mem  [COEF_DEPTH_DEF];
  bit                       coef_seen [COEF_DEPTH_DEF];
  logic [IDX_W-1:0]         tap_col_idx [TAPS_DEF] = '{default: '0};
  logic signed [WGT_W-1:0]  tap_col_wgt [TAPS_DEF] = '{default: '0};
  logic [IDX_W-1:0]         tap_row_idx [TAPS_DEF] = '{default: '0};
  logic signed [WGT_W-1:0]  tap_row_wgt [TAPS_DEF] = '{default: '0};
  int                       row_width = MAX_ROW_WIDTH_DEF;

  out_t      results_due [$];
  stim_row_t plan [$];
  int        beats_done = 0;
  int        errors     = 0;
  int        gap_odds   = 0;

  separable_4x4_spline_interpolation_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_t scramble();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(in_t)-1:0];
  endfunction

  function automatic in_t mk_coef(input logic [CADDR_W-1:0] addr,
                                  input logic signed [COEF_W-1:0] data);
    in_t b;
    b = scramble();
    b.opcode    = OP_WR_COEF;
    b.coef_addr = addr;
    b.coef_data = data;
    return b;
  endfunction

  function automatic in_t mk_tap(input logic [1:0] t, input logic [IDX_W-1:0] xi,
                                 input logic signed [WGT_W-1:0] xw,
                                 input logic [IDX_W-1:0] yi,
                                 input logic signed [WGT_W-1:0] yw);
    in_t b;
    b = scramble();
    b.opcode   = OP_SET_TAP;
    b.tap      = t;
    b.x_index  = xi;
    b.x_weight = xw;
    b.y_index  = yi;
    b.y_weight = yw;
    return b;
  endfunction

  function automatic in_t mk_eval();
    in_t b;
    b = scramble();
    b.opcode = OP_EVAL;
    return b;
  endfunction

  function automatic logic signed [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return W_NEG1;
      1: return W_MAX;
      2: return '0;
      default: return WGT_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic out_t outcome(input int v, input status_t s);
    out_t o;
    o.interp_value = v[COEF_W-1:0];
    o.status       = s;
    return o;
  endfunction

  function automatic stim_row_t row(input bit is_cfg, input logic [RW_W-1:0] v,
                                    input in_t b, input bit typed, input out_t w);
    stim_row_t r;
    r.is_cfg  = is_cfg;
    r.cfg_val = v;
    r.beat    = b;
    r.typed   = typed;
    r.want    = w;
    return r;
  endfunction

  function automatic out_t interp_predict();
    longint acc;
    longint rounded;
    int     addr;
    bit     oob;
    out_t   o;
    acc = 0;
    oob = 1'b0;
    for (int k = 0; k < TAPS_DEF; k++) begin
      for (int j = 0; j < TAPS_DEF; j++) begin
        addr = int'(tap_row_idx[k]) * row_width + int'(tap_col_idx[j]);
        if (int'(tap_col_idx[j]) >= row_width || addr >= COEF_DEPTH_DEF) oob = 1'b1;
        else acc += longint'(coef_mem[addr]) * longint'(tap_row_wgt[k])
                    * longint'(tap_col_wgt[j]);
      end
    end
    // add half an lsb, then floor shift out the q2.30 fraction
    rounded = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
    o.status = ST_OK;
    if (rounded > VAL_MAX) begin
      rounded  = VAL_MAX;
      o.status = ST_SAT;
    end else if (rounded < VAL_MIN) begin
      rounded  = VAL_MIN;
      o.status = ST_SAT;
    end
    if (oob) o.status = ST_RANGE;
    o.interp_value = rounded[COEF_W-1:0];
    return o;
  endfunction

  // update the predictor with one accepted beat
  function automatic void absorb(input in_t b, input bit typed, input out_t want);
    case (b.opcode)
      OP_WR_COEF: begin
        coef_mem[b.coef_addr]  = b.coef_data;
        coef_seen[b.coef_addr] = 1'b1;
        beats_done++;
      end
      OP_SET_TAP: begin
        tap_col_idx[b.tap] = b.x_index;
        tap_col_wgt[b.tap] = b.x_weight;
        tap_row_idx[b.tap] = b.y_index;
        tap_row_wgt[b.tap] = b.y_weight;
        beats_done++;
      end
      OP_EVAL: begin
        results_due.push_back(typed ? want : interp_predict());
        beats_done++;
      end
      default: ;
    endcase
  endfunction

  task automatic put_beat(input in_t b);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // an evaluation may only touch written entries, so fill any gaps first
  task automatic issue(input in_t b, input bit typed, input out_t want);
    in_t fill;
    int  addr;
    if (b.opcode == OP_EVAL) begin
      for (int k = 0; k < TAPS_DEF; k++) begin
        for (int j = 0; j < TAPS_DEF; j++) begin
          addr = int'(tap_row_idx[k]) * row_width + int'(tap_col_idx[j]);
          if (int'(tap_col_idx[j]) < row_width && addr < COEF_DEPTH_DEF
              && !coef_seen[addr]) begin
            fill = mk_coef(addr[CADDR_W-1:0], pick_coef());
            put_beat(fill);
            absorb(fill, 1'b0, '0);
          end
        end
      end
    end
    put_beat(b);
    absorb(b, typed, want);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_row_width(input logic [RW_W-1:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (v == '0) row_width = 1;
    else if (int'(v) > MAX_ROW_WIDTH_DEF) row_width = MAX_ROW_WIDTH_DEF;
    else row_width = int'(v);
  endtask

  always @(posedge clk) begin : watch_results
    out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("unexpected result beat: interp_value %0d status %0d",
               out_data.interp_value, out_data.status);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (out_data.interp_value !== want.interp_value) begin
          $error("interp_value: expected %0d, got %0d",
                 want.interp_value, out_data.interp_value);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [RW_W-1:0] phase_widths [9];
    in_t             b;
    int              pick, mode, base_x, base_y, xi, yi, a;
    int              per_phase, stop_at, hold_at, quiet_from;
    bit              held;

    phase_widths = '{9'd2, 9'd17, 9'd100, 9'd255, 9'd300, 9'd4, 9'd1, 9'd128, 9'd256};
    base_x = 0;
    base_y = 0;

    // directed table: extremes, saturation, ignored opcode, range errors
    plan.push_back(row(1'b0, '0, mk_coef(16'd0, C_MAX), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b1, outcome(0, ST_OK)));
    plan.push_back(row(1'b0, '0, mk_tap(2'd0, 8'd0, W_NEG1, 8'd0, W_NEG1), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b1, outcome(VAL_MAX, ST_OK)));
    plan.push_back(row(1'b0, '0, mk_coef(16'd0, C_MIN), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b1, outcome(VAL_MIN, ST_OK)));
    // two taps of -1.0 on the same entry scale it by four
    plan.push_back(row(1'b0, '0, mk_tap(2'd1, 8'd0, W_NEG1, 8'd0, W_NEG1), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b1, outcome(VAL_MIN, ST_SAT)));
    plan.push_back(row(1'b0, '0, mk_coef(16'd0, C_MAX), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b1, outcome(VAL_MAX, ST_SAT)));
    plan.push_back(row(1'b0, '0, mk_coef(16'd255, C_MIN), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_coef(16'd65280, 24'sd1234567), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_coef(16'hFFFF, 24'sh555555), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_tap(2'd2, 8'd255, W_MAX, 8'd255, W_MAX), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_tap(2'd3, 8'd1, 16'sh4000, 8'd1, 16'shC000),
                       1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b0, '0));
    plan.push_back(row(1'b0, '0, in_t'('1), 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b0, '0));
    plan.push_back(row(1'b1, 9'd0, '0, 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b0, '0));
    plan.push_back(row(1'b1, 9'h1FF, '0, 1'b0, '0));
    plan.push_back(row(1'b0, '0, mk_eval(), 1'b0, '0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_odds = 4;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_row_width(plan[i].cfg_val);
      else issue(plan[i].beat, plan[i].typed, plan[i].want);
    end

    per_phase  = (ITEM_TARGET - beats_done) / $size(phase_widths);
    quiet_from = ITEM_TARGET - ITEM_TARGET / 10;
    foreach (phase_widths[p]) begin
      set_row_width(phase_widths[p]);
      case ($urandom_range(0, 3))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        2:       gap_odds = 8;
        default: gap_odds = 20;
      endcase
      stop_at = beats_done + per_phase;
      hold_at = beats_done + $urandom_range(0, per_phase - 1);
      held    = 1'b0;
      while (beats_done < stop_at) begin
        if (beats_done >= quiet_from) gap_odds = 0;
        if (!held && beats_done >= hold_at) begin
          drain();
          held = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // full kernel: four taps, maybe touch the window, evaluate
          if ($urandom_range(0, 1) == 0) begin
            base_x = $urandom_range(0, (row_width > 4) ? row_width - 4 : 0);
            base_y = $urandom_range(0, 252);
          end
          mode = $urandom_range(0, 3);
          for (int t = 0; t < TAPS_DEF; t++) begin
            case (mode)
              0: begin
                xi = $urandom_range(0, 255);
                yi = $urandom_range(0, 255);
              end
              1: begin
                xi = $urandom_range(0, row_width - 1);
                yi = base_y + t;
              end
              default: begin
                xi = base_x + t;
                yi = base_y + t;
              end
            endcase
            issue(mk_tap(2'(t), xi[IDX_W-1:0], pick_weight(), yi[IDX_W-1:0], pick_weight()),
                  1'b0, '0);
          end
          repeat ($urandom_range(0, 2)) begin
            a = (base_y + $urandom_range(0, 3)) * row_width + base_x + $urandom_range(0, 3);
            issue(mk_coef(a[CADDR_W-1:0], pick_coef()), 1'b0, '0);
          end
          issue(mk_eval(), 1'b0, '0);
        end else if (pick < 80) begin
          issue(mk_coef(CADDR_W'($urandom), pick_coef()), 1'b0, '0);
        end else if (pick < 87) begin
          b = scramble();
          b.opcode = OP_NONE;
          issue(b, 1'b0, '0);
        end else if (pick < 94) begin
          issue(mk_tap(2'($urandom), IDX_W'($urandom), pick_weight(), IDX_W'($urandom),
                       pick_weight()), 1'b0, '0);
          issue(mk_eval(), 1'b0, '0);
        end else begin
          issue(mk_eval(), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
src/sp4x4_pkg.sv
src/sp4x4_front.sv
src/sp4x4_back.sv
src/separable_4x4_spline_interpolation_unit.sv
tb/separable_4x4_spline_interpolation_unit_tb.sv
